[design/vibration_pattern_sequencer_macros.svh]
// Assertion helpers for the checker in vps_checker.sv.
`ifndef VIBRATION_PATTERN_SEQUENCER_MACROS_SVH
`define VIBRATION_PATTERN_SEQUENCER_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define VPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vps check failed");

// Next-cycle implication, ignored while reset is held.
`define VPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vps check failed");

// Next-cycle implication that is also checked during reset.
`define VPS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("vps check failed");

`endif

[design/vps_pkg.sv]
`timescale 1ns / 1ps

package vps_pkg;

    localparam int MAX_STEPS = 128;
    localparam int SONG_LEN  = 73;
    localparam int STEP_W    = 7;
    localparam int DUR_W     = 10;
    localparam int LEN_W     = 9;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        PAT_SONG     = 3'd0,
        PAT_SOFT     = 3'd1,
        PAT_300MS    = 3'd2,
        PAT_200MS    = 3'd3,
        PAT_300MS_X2 = 3'd4,
        PAT_100MS_X2 = 3'd5
    } pattern_t;

    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] dur;
    } step_t;

    // Steps a pattern plays, capped at MAX_STEPS.
    function automatic logic [LEN_W-1:0] pat_len(pattern_t p);
        logic [LEN_W-1:0] n;
        unique case (p)
            PAT_SONG:                   n = LEN_W'(SONG_LEN);
            PAT_SOFT, PAT_300MS,
            PAT_200MS:                  n = LEN_W'(2);
            PAT_300MS_X2, PAT_100MS_X2: n = LEN_W'(4);
            default:                    n = '0;
        endcase
        if (n > LEN_W'(MAX_STEPS)) begin
            n = LEN_W'(MAX_STEPS);
        end
        return n;
    endfunction

endpackage

[design/vibration_pattern_sequencer.sv]
`timescale 1ns / 1ps

// Vibration pattern sequencer. Plays one of six built-in motor on/off patterns
// (song, soft, 300 ms, 200 ms, 300 ms double, 100 ms double). Send action 1 with a
// pattern to start it (only while vibration_enable is set), action 0 once per
// millisecond to advance it, action 2 to stop. Every request yields exactly one
// result with the motor level, the busy flag and the current step. The block takes
// one request per clock while m_tready does not stall the output register: a request
// sits in the input register, the pattern ROM and the countdown update the state
// combinationally, and the result lands in the output register, which drives m_tvalid.
// Write vibration_enable only while no request is in flight.
module vibration_pattern_sequencer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // vibration_enable

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [1:0] action, [4:2] pattern_select

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // [0] motor_on, [1] busy_res, [8:2] step_number
);

    logic                        in_vld_reg;
    logic [4:0]                  in_data_reg;
    logic                        enable_reg;
    logic                        playing_reg, playing_next;
    vps_pkg::pattern_t           cur_pat_reg, cur_pat_next;
    logic [vps_pkg::STEP_W-1:0]  step_idx_reg, step_idx_next;
    logic [vps_pkg::DUR_W-1:0]   remain_reg, remain_next;
    logic                        drive_reg, drive_next;
    logic                        out_vld_reg;
    logic [8:0]                  out_data_reg, out_data_next;

    logic                        out_ready;
    logic                        fire;
    vps_pkg::action_t            act;
    logic [2:0]                  sel;
    logic [vps_pkg::STEP_W:0]    next_idx;
    vps_pkg::pattern_t           rom_pat;
    logic [vps_pkg::STEP_W-1:0]  rom_idx;
    vps_pkg::step_t              rom_step;

    assign out_ready = ~out_vld_reg | m_tready;
    assign fire      = in_vld_reg & out_ready;
    assign s_tready  = ~in_vld_reg | out_ready;

    assign act      = vps_pkg::action_t'(in_data_reg[1:0]);
    assign sel      = in_data_reg[4:2];
    assign next_idx = {1'b0, step_idx_reg} + 1'b1;

    // Start reads step 0 of the new pattern, a tick reads the following step.
    assign rom_pat = (act == vps_pkg::ACT_START) ? vps_pkg::pattern_t'(sel) : cur_pat_reg;
    assign rom_idx = (act == vps_pkg::ACT_START) ? '0 : next_idx[vps_pkg::STEP_W-1:0];

    vps_rom u_rom (
        .pattern  (rom_pat),
        .step_idx (rom_idx),
        .step     (rom_step)
    );

    always_comb begin
        playing_next  = playing_reg;
        cur_pat_next  = cur_pat_reg;
        step_idx_next = step_idx_reg;
        remain_next   = remain_reg;
        drive_next    = drive_reg;
        unique case (act)
            vps_pkg::ACT_TICK: begin
                if (playing_reg) begin
                    if (remain_reg > vps_pkg::DUR_W'(1)) begin
                        remain_next = remain_reg - 1'b1;
                    end else if ({1'b0, next_idx} >= vps_pkg::pat_len(cur_pat_reg)) begin
                        playing_next  = 1'b0;
                        step_idx_next = '0;
                        remain_next   = '0;
                        drive_next    = 1'b0;
                    end else begin
                        step_idx_next = next_idx[vps_pkg::STEP_W-1:0];
                        drive_next    = rom_step.level;
                        remain_next   = rom_step.dur;
                    end
                end
            end
            vps_pkg::ACT_START: begin
                if (enable_reg && sel <= 3'(vps_pkg::PAT_100MS_X2)) begin
                    cur_pat_next  = vps_pkg::pattern_t'(sel);
                    playing_next  = 1'b1;
                    step_idx_next = '0;
                    drive_next    = rom_step.level;
                    remain_next   = rom_step.dur;
                end
            end
            vps_pkg::ACT_STOP: begin
                playing_next  = 1'b0;
                step_idx_next = '0;
                remain_next   = '0;
                drive_next    = 1'b0;
            end
            default: ;
        endcase
        out_data_next = {(playing_next ? step_idx_next : {vps_pkg::STEP_W{1'b0}}),
                         playing_next, drive_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            enable_reg   <= 1'b0;
            playing_reg  <= 1'b0;
            cur_pat_reg  <= vps_pkg::PAT_SONG;
            step_idx_reg <= '0;
            remain_reg   <= '0;
            drive_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                enable_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (fire) begin
                playing_reg  <= playing_next;
                cur_pat_reg  <= cur_pat_next;
                step_idx_reg <= step_idx_next;
                remain_reg   <= remain_next;
                drive_reg    <= drive_next;
                out_vld_reg  <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata[4:0];
        end
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'b0, out_data_reg};

endmodule

[design/vps_rom.sv]
`timescale 1ns / 1ps

module vps_rom (
    input  vps_pkg::pattern_t                pattern,
    input  logic [vps_pkg::STEP_W-1:0]       step_idx,
    output vps_pkg::step_t                   step
);

    always_comb begin
        step.level = 1'b0;
        step.dur   = '0;
        unique case (pattern)
            vps_pkg::PAT_SONG: begin
                if (step_idx >= vps_pkg::STEP_W'(vps_pkg::SONG_LEN - 1)) begin
                    step.level = 1'b0;
                    step.dur   = vps_pkg::DUR_W'(200);
                end else begin
                    unique case (step_idx[1:0])
                        2'd0: begin step.level = 1'b1; step.dur = vps_pkg::DUR_W'(300);  end
                        2'd1: begin step.level = 1'b0; step.dur = vps_pkg::DUR_W'(500);  end
                        2'd2: begin step.level = 1'b1; step.dur = vps_pkg::DUR_W'(300);  end
                        default: begin
                            step.level = 1'b0;
                            step.dur   = vps_pkg::DUR_W'(1000);
                        end
                    endcase
                end
            end
            vps_pkg::PAT_SOFT, vps_pkg::PAT_100MS_X2: begin
                step.level = ~step_idx[0];
                step.dur   = vps_pkg::DUR_W'(100);
            end
            vps_pkg::PAT_300MS, vps_pkg::PAT_300MS_X2: begin
                step.level = ~step_idx[0];
                step.dur   = vps_pkg::DUR_W'(300);
            end
            vps_pkg::PAT_200MS: begin
                step.level = ~step_idx[0];
                step.dur   = vps_pkg::DUR_W'(200);
            end
            default: begin
                step.level = 1'b0;
                step.dur   = '0;
            end
        endcase
    end

endmodule

[design/vps_checker.sv]
`timescale 1ns / 1ps
`include "vibration_pattern_sequencer_macros.svh"

module vps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `VPS_ASSERT_NEXT_ALWAYS(a_reset_clears_out, aclk, !aresetn, !m_tvalid)
    `VPS_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `VPS_ASSERT_IMP(a_idle_is_off, aclk, aresetn, m_tvalid && !m_tdata[1], !m_tdata[0] && m_tdata[8:2] == 7'd0)
    `VPS_ASSERT_IMP(a_step_in_range, aclk, aresetn, m_tvalid, m_tdata[8:2] < 7'(vps_pkg::SONG_LEN))

endmodule

bind vibration_pattern_sequencer vps_checker u_vps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[dv/vps_pattern_checker.sv]
`timescale 1ns / 1ps

module vps_pattern_checker
    import vps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,       // [1:0] action, [4:2] pattern_select
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,       // [0] motor_on, [1] busy_res, [8:2] step_number
    output int unsigned pending,
    output int unsigned errors
);

    localparam int unsigned NUM_PATTERNS = 6;

    // Packed so that it lines up with m_tdata[8:0].
    typedef struct packed {
        logic [STEP_W-1:0] step_number;
        logic              busy_res;
        logic              motor_on;
    } motor_status_t;

    logic              enable_q;
    logic              playing_q;
    pattern_t          pattern_q;
    logic [STEP_W-1:0] step_q;
    logic [DUR_W-1:0]  remaining_q;
    logic              level_q;

    motor_status_t expected_status[$];

    function automatic int unsigned steps_in(pattern_t p);
        int unsigned n;
        if (p == PAT_SONG) begin
            n = SONG_LEN;
        end else if (p == PAT_300MS_X2 || p == PAT_100MS_X2) begin
            n = 4;
        end else begin
            n = 2;
        end
        return (n > MAX_STEPS) ? MAX_STEPS : n;
    endfunction

    function automatic step_t pattern_step(pattern_t p, logic [STEP_W-1:0] idx);
        step_t e;
        if (p == PAT_SONG) begin
            // song ends on a quiet 200 ms step
            if (idx >= SONG_LEN - 1) begin
                e = '{level: 1'b0, dur: DUR_W'(200)};
            end else begin
                case (idx[1:0])
                    2'd0:    e = '{level: 1'b1, dur: DUR_W'(300)};
                    2'd1:    e = '{level: 1'b0, dur: DUR_W'(500)};
                    2'd2:    e = '{level: 1'b1, dur: DUR_W'(300)};
                    default: e = '{level: 1'b0, dur: DUR_W'(1000)};
                endcase
            end
        end else begin
            e.level = ~idx[0];
            case (p)
                PAT_SOFT, PAT_100MS_X2: e.dur = DUR_W'(100);
                PAT_300MS, PAT_300MS_X2: e.dur = DUR_W'(300);
                default:                 e.dur = DUR_W'(200);
            endcase
        end
        return e;
    endfunction

    function automatic void park_motor();
        playing_q   = 1'b0;
        step_q      = '0;
        remaining_q = '0;
        level_q     = 1'b0;
    endfunction

    function automatic motor_status_t advance_pattern(action_t act, logic [2:0] sel);
        motor_status_t r;
        step_t         e;
        case (act)
            ACT_TICK: begin
                if (playing_q) begin
                    if (remaining_q > 1) begin
                        remaining_q = remaining_q - 1'b1;
                    end else if (int'(step_q) + 1 >= int'(steps_in(pattern_q))) begin
                        park_motor();
                    end else begin
                        step_q      = step_q + 1'b1;
                        e           = pattern_step(pattern_q, step_q);
                        level_q     = e.level;
                        remaining_q = e.dur;
                    end
                end
            end
            ACT_START: begin
                if (enable_q && sel < NUM_PATTERNS) begin
                    pattern_q   = pattern_t'(sel);
                    playing_q   = 1'b1;
                    step_q      = '0;
                    e           = pattern_step(pattern_q, step_q);
                    level_q     = e.level;
                    remaining_q = e.dur;
                end
            end
            ACT_STOP: begin
                park_motor();
            end
            default: begin
            end
        endcase
        r.motor_on    = level_q;
        r.busy_res    = playing_q;
        r.step_number = playing_q ? step_q : '0;
        return r;
    endfunction

    always @(posedge aclk) begin
        motor_status_t got;
        motor_status_t want;
        if (!aresetn) begin
            enable_q  = 1'b0;
            pattern_q = PAT_SONG;
            park_motor();
            expected_status.delete();
        end else begin
            if (cfg_wr_en) begin
                enable_q = cfg_wr_data;
            end
            // results first: a result always belongs to an older request
            if (m_tvalid && m_tready) begin
                got = m_tdata[8:0];
                if (expected_status.size() == 0) begin
                    $error("unexpected result: motor_on %0d busy_res %0d step_number %0d",
                           got.motor_on, got.busy_res, got.step_number);
                    errors++;
                end else begin
                    want = expected_status.pop_front();
                    if (got.motor_on !== want.motor_on) begin
                        $error("motor_on: expected %0d, actual %0d",
                               want.motor_on, got.motor_on);
                        errors++;
                    end
                    if (got.busy_res !== want.busy_res) begin
                        $error("busy_res: expected %0d, actual %0d",
                               want.busy_res, got.busy_res);
                        errors++;
                    end
                    if (got.step_number !== want.step_number) begin
                        $error("step_number: expected %0d, actual %0d",
                               want.step_number, got.step_number);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_status.push_back(
                    advance_pattern(action_t'(s_tdata[1:0]), s_tdata[4:2]));
            end
        end
        pending = expected_status.size();
    end

endmodule

[dv/tb_vibration_pattern_sequencer.sv]
`timescale 1ns / 1ps

module tb_vibration_pattern_sequencer;
    import vps_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;

    int unsigned pending;
    int unsigned errors;
    int unsigned n_sent      = 0;
    bit          idle_on     = 1'b1;
    bit          hold_off_req = 1'b0;

    vibration_pattern_sequencer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    vps_pattern_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .pending     (pending),
        .errors      (errors)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        wait (aresetn);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                gap = idle_on ? $urandom_range(0, 9) : 0;
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_tready <= 1'b1;
                @(posedge aclk iff m_tvalid);
            end
        end
    end

    task automatic send_req(input logic [1:0] act, input logic [2:0] sel);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, sel, act};
        @(posedge aclk iff s_tready);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_enable(input logic v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_random(input logic en, input int unsigned quota);
        int unsigned first;
        int          k;
        wait_drained();
        write_enable(en);
        first = n_sent;
        while (n_sent - first < quota) begin
            if ($urandom_range(0, 9) < 7) begin
                // start, a run of ticks, sometimes a stop
                send_req(ACT_START, 3'($urandom_range(0, 5)));
                k = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 420)
                                                : $urandom_range(0, 40);
                repeat (k) send_req(ACT_TICK, 3'($urandom));
                if ($urandom_range(0, 2) == 0) begin
                    send_req(ACT_STOP, 3'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_req(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
                end
            end
        end
    endtask

    initial begin
        int       ticks;
        pattern_t full_pats[3] = '{PAT_SOFT, PAT_200MS, PAT_100MS_X2};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // disabled after reset: start ignored, stop still forces off
        write_enable(1'b0);
        send_req(ACT_START, PAT_300MS);
        send_req(ACT_TICK, 3'd0);
        send_req(ACT_STOP, 3'd0);
        send_req(ACT_NOP, 3'd7);
        wait_drained();
        write_enable(1'b1);

        // each valid start aborts the one before it; starts with select 6 and 7 are ignored
        send_req(ACT_START, PAT_SONG);
        send_req(ACT_TICK, 3'd0);
        send_req(ACT_START, PAT_SOFT);
        send_req(ACT_TICK, 3'd0);
        send_req(ACT_START, PAT_300MS);
        send_req(ACT_START, PAT_200MS);
        send_req(ACT_START, PAT_300MS_X2);
        send_req(ACT_START, PAT_100MS_X2);
        send_req(ACT_START, 3'd6);
        send_req(ACT_START, 3'd7);
        send_req(ACT_NOP, 3'd0);
        send_req(ACT_TICK, 3'd7);
        send_req(ACT_STOP, 3'd7);
        send_req(ACT_TICK, 3'd0);
        send_req(ACT_STOP, 3'd0);
        send_req(ACT_START, PAT_100MS_X2);
        wait_drained();

        // pattern keeps playing after disable; stop works regardless
        write_enable(1'b0);
        send_req(ACT_START, PAT_SONG);
        send_req(ACT_TICK, 3'd0);
        send_req(ACT_STOP, 3'd0);
        wait_drained();
        write_enable(1'b1);

        // short patterns played to the end, back to back
        idle_on = 1'b0;
        foreach (full_pats[i]) begin
            case (full_pats[i])
                PAT_SOFT:  ticks = 200;
                PAT_200MS: ticks = 400;
                default:   ticks = 400;
            endcase
            send_req(ACT_START, full_pats[i]);
            repeat (ticks + 3) send_req(ACT_TICK, 3'($urandom));
        end
        wait_drained();

        // receiver holds off while requests keep coming, then sender waits it out
        hold_off_req = 1'b1;
        send_req(ACT_START, PAT_100MS_X2);
        repeat (60) send_req(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
        wait_drained();
        idle_on = 1'b1;

        run_random(1'b1, 500);
        run_random(1'b0, 150);
        run_random(1'b1, 200);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
